FILE: hdl/rlsr_pkg.sv
// ----------------------------------------------------------------------------
// rlsr_pkg
// Shared types and constants for the random looping shift register.
// ----------------------------------------------------------------------------
package rlsr_pkg;

   localparam logic [15:0] LOOP_RESET  = 16'hACE1;
   localparam logic [31:0] LCG_MUL     = 32'd1664525;
   localparam logic [31:0] LCG_ADD     = 32'd1013904223;
   // LCG value one step past the reset seed of one
   localparam logic [31:0] LCG_FIRST   = LCG_MUL + LCG_ADD;
   localparam logic signed [11:0] CLICK_LEVEL = 12'sd1200;

   typedef struct packed {
      logic        clock_edge;
      logic [11:0] rate_knob;
      logic [11:0] chance_knob;
   } item_type;

   typedef struct packed {
      logic signed [11:0] cv_raw;
      logic signed [11:0] cv_smoothed;
      logic signed [11:0] click_main;
      logic signed [10:0] click_half;
   } result_type;

endpackage

FILE: hdl/random_looping_shift_register.sv
// ----------------------------------------------------------------------------
// random_looping_shift_register
// Turing-machine style looping shift register with CV and click outputs.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel: one item per audio tick (clock edge flag, rate and chance
//    knobs). Accepted when req_valid is high and req_stall is low.
//  - rsp_* channel: one result item per input item (raw CV, smoothed CV and
//    two click levels), taken when rsp_valid is high and rsp_stall is low.
//  - An accepted item passes from the input register to the result register and
//    shows on rsp_*. Throughput is one item per cycle while rsp_stall is low.
//  - Two register stages: an input register and a result register. The tick
//    work (divider, rotate with LCG flip, smoother) sits between them; the
//    LCG multiply is done one rotation ahead so only a compare is in path.
//  - A stalled result holds; the input register still accepts while it is empty
//    or the result register is empty or being drained, else req_stall goes high.
//  - Reset (synchronous) empties both stages and loads the loop register
//    with 0xACE1, the LCG one step past seed one, other step state with zero.
// ----------------------------------------------------------------------------
module random_looping_shift_register (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_clock_edge,
   input  logic [11:0]        req_rate_knob,
   input  logic [11:0]        req_chance_knob,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [11:0] rsp_cv_raw,
   output logic signed [11:0] rsp_cv_smoothed,
   output logic signed [11:0] rsp_click_main,
   output logic signed [10:0] rsp_click_half
);
   import rlsr_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic       out_free;
   logic       in_free;
   logic       advance;     // item moves from input register to result register
   logic       accept;
   result_type step_result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign in_free   = !in_valid_ff || out_free;
   assign req_stall = !in_free;
   assign accept    = req_valid && in_free;

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);
   end

   rlsr_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.clock_edge  <= req_clock_edge;
         in_item_ff.rate_knob   <= req_rate_knob;
         in_item_ff.chance_knob <= req_chance_knob;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_cv_raw      = out_ff.cv_raw;
   assign rsp_cv_smoothed = out_ff.cv_smoothed;
   assign rsp_click_main  = out_ff.click_main;
   assign rsp_click_half  = out_ff.click_half;

endmodule

FILE: hdl/rlsr_step.sv
// ----------------------------------------------------------------------------
// rlsr_step
// Loop register, divider, LCG and smoother state; computes one tick per fire.
// ----------------------------------------------------------------------------
module rlsr_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  rlsr_pkg::item_type  item,
   output rlsr_pkg::result_type result
);
   import rlsr_pkg::*;

   logic [15:0] loop_ff,   loop_in;
   logic [6:0]  div_ff,    div_in;
   logic [7:0]  chance_ff, chance_in;
   logic [31:0] lcg_ff,    lcg_in;     // holds the seed value the next rotation uses
   logic [11:0] smooth_ff, smooth_in;

   logic [6:0]  div_inc;
   logic        expire;
   logic        rotate;
   logic        flip;
   logic [15:0] biased;
   logic [11:0] cv;
   logic [16:0] acc;

   always_comb begin
      div_inc = div_ff + 7'd1;
      expire  = div_inc > {1'b0, item.rate_knob[11:6]};
      div_in  = expire ? 7'd0 : div_inc;
      rotate  = expire & item.clock_edge;

      flip    = lcg_ff[31:24] < chance_ff;
      loop_in = rotate ? {loop_ff[0] ^ flip, loop_ff[15:1]} : loop_ff;
      lcg_in  = rotate ? lcg_ff * LCG_MUL + LCG_ADD : lcg_ff;

      chance_in = item.chance_knob[11:4];

      // register minus 32768, then floor shift by four
      biased = {~loop_in[15], loop_in[14:0]};
      cv     = biased[15:4];

      // old*15 + cv, then floor shift by four; result always fits 12 bits
      acc       = {smooth_ff[11], smooth_ff, 4'b0000} - {{5{smooth_ff[11]}}, smooth_ff}
                  + {{5{cv[11]}}, cv};
      smooth_in = acc[15:4];

      result.cv_raw      = cv;
      result.cv_smoothed = smooth_in;
      result.click_main  = loop_in[0] ? CLICK_LEVEL : -CLICK_LEVEL;
      result.click_half  = loop_in[0] ? CLICK_LEVEL[11:1] : -CLICK_LEVEL[11:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_ff   <= LOOP_RESET;
         div_ff    <= '0;
         chance_ff <= '0;
         lcg_ff    <= LCG_FIRST;
         smooth_ff <= '0;
      end else if (fire) begin
         loop_ff   <= loop_in;
         div_ff    <= div_in;
         chance_ff <= chance_in;
         lcg_ff    <= lcg_in;
         smooth_ff <= smooth_in;
      end
   end

endmodule
